// ----- hdl/gol24_pkg.sv -----
// Shared constants and functions for the extended Golay (24,12) decoder.
// Holds the parity matrix rows, the matrix product and the weight test.
// No dependencies.
package gol24_pkg;

  localparam int HalfW = 12;

  typedef logic [HalfW-1:0] half_t;

  typedef struct packed {
    logic  hit;
    half_t e_main;
    half_t e_other;
  } srch_t;

  localparam half_t ROWS [HalfW] = '{
    12'h7ff, 12'hee2, 12'hdc5, 12'hb8b, 12'hf16, 12'he2d,
    12'hc5b, 12'h8b7, 12'h96e, 12'hadc, 12'hdb8, 12'hb71
  };

  localparam half_t TOP_BIT = half_t'(1) << (HalfW - 1);

  function automatic half_t mat_mul(input half_t v);
    half_t r;
    r = '0;
    for (int j = 0; j < HalfW; j++) begin
      r[HalfW-1-j] = ^(ROWS[j] & v);
    end
    return r;
  endfunction

  function automatic logic weight_le(input half_t v, input logic [3:0] lim);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < HalfW; k++) begin
      n = n + {3'b000, v[k]};
    end
    return n <= lim;
  endfunction

endpackage

// ----- hdl/gol24_search.sv -----
// Error pattern search for one syndrome of the Golay (24,12) decoder.
// Tries the syndrome alone, then each matrix row; lowest row wins.
// Depends on gol24_pkg.
module gol24_search (
  input  gol24_pkg::half_t syn,
  output gol24_pkg::srch_t res
);

  always_comb begin
    res.hit     = 1'b0;
    res.e_main  = '0;
    res.e_other = '0;
    for (int i = gol24_pkg::HalfW - 1; i >= 0; i--) begin
      if (gol24_pkg::weight_le(syn ^ gol24_pkg::ROWS[i], 4'd2)) begin
        res.hit     = 1'b1;
        res.e_main  = syn ^ gol24_pkg::ROWS[i];
        res.e_other = gol24_pkg::TOP_BIT >> i;
      end
    end
    if (gol24_pkg::weight_le(syn, 4'd3)) begin
      res.hit     = 1'b1;
      res.e_main  = syn;
      res.e_other = '0;
    end
  end

endmodule

// ----- hdl/gol24_core.sv -----
// Combinational decode of one 24-bit word: syndromes, both searches, correction.
// Depends on gol24_pkg and gol24_search.
module gol24_core (
  input  logic [23:0]      word,
  output gol24_pkg::half_t info_fix,
  output gol24_pkg::half_t par_fix,
  output logic             uncorr
);

  gol24_pkg::half_t info;
  gol24_pkg::half_t par;
  gol24_pkg::half_t s;
  gol24_pkg::half_t q;
  gol24_pkg::srch_t res_s;
  gol24_pkg::srch_t res_q;

  assign info = word[23:12];
  assign par  = word[11:0];
  assign s    = info ^ gol24_pkg::mat_mul(par);
  assign q    = gol24_pkg::mat_mul(s);

  gol24_search u_search_s (
    .syn (s),
    .res (res_s)
  );

  gol24_search u_search_q (
    .syn (q),
    .res (res_q)
  );

  always_comb begin
    info_fix = info;
    par_fix  = par;
    uncorr   = 1'b0;
    if (res_s.hit) begin
      info_fix = info ^ res_s.e_main;
      par_fix  = par ^ res_s.e_other;
    end else if (res_q.hit) begin
      info_fix = info ^ res_q.e_other;
      par_fix  = par ^ res_q.e_main;
    end else begin
      uncorr = 1'b1;
    end
  end

endmodule

// ----- hdl/golay24_decoder.sv -----
// Top level of the extended Golay (24,12) decoder.
// Depends on gol24_pkg and gol24_core.
// A word accepted into the input register is decoded by the core and lands in the result register.
// Throughput: one word per cycle; busy is low outside reset, so start may be held high.
// The input register and the result register are the only storage in the path.
// Reset clears both valid flags and holds busy high; the receiver cannot stall, so no result waits.
module golay24_decoder (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [23:0]              in_received_word,
  output logic                     out_valid,
  output gol24_pkg::half_t         out_corrected_info,
  output gol24_pkg::half_t         out_corrected_parity,
  output logic                     out_uncorrectable
);

  logic             in_valid_r;
  logic [23:0]      in_word_r;
  logic             out_valid_r;
  gol24_pkg::half_t info_r;
  gol24_pkg::half_t par_r;
  logic             uncorr_r;
  gol24_pkg::half_t info_nxt;
  gol24_pkg::half_t par_nxt;
  logic             uncorr_nxt;

  assign busy = !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_word_r <= in_received_word;
    end
    if (in_valid_r) begin
      info_r   <= info_nxt;
      par_r    <= par_nxt;
      uncorr_r <= uncorr_nxt;
    end
  end

  gol24_core u_core (
    .word     (in_word_r),
    .info_fix (info_nxt),
    .par_fix  (par_nxt),
    .uncorr   (uncorr_nxt)
  );

  assign out_valid            = out_valid_r;
  assign out_corrected_info   = info_r;
  assign out_corrected_parity = par_r;
  assign out_uncorrectable    = uncorr_r;

endmodule

// ----- hdl/gol24_checker.sv -----
// Port-level checks for the Golay (24,12) decoder, bound to the top level.
// Depends on gol24_pkg and golay24_decoder.
module gol24_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic [23:0]          in_received_word,
  input logic                 out_valid,
  input gol24_pkg::half_t     out_corrected_info,
  input gol24_pkg::half_t     out_corrected_parity,
  input logic                 out_uncorrectable
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised although the decoder never stalls");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(start && rst_n, 2) && $past(rst_n)) |-> out_valid)
    else $error("accepted word produced no result two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 2))
    else $error("result strobe without an accepted word");

  a_codeword: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_uncorrectable) |->
      (out_corrected_info == gol24_pkg::mat_mul(out_corrected_parity)))
    else $error("corrected word is not a codeword");

  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({out_corrected_info, out_corrected_parity}
                              ^ $past(in_received_word, 2)) <= 3))
    else $error("correction changed more than three bits");

endmodule

bind golay24_decoder gol24_checker u_gol24_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .in_received_word     (in_received_word),
  .out_valid            (out_valid),
  .out_corrected_info   (out_corrected_info),
  .out_corrected_parity (out_corrected_parity),
  .out_uncorrectable    (out_uncorrectable)
);
